FILE: hw/rtl/ima_adpcm_encoder_defines.svh
// Assertion macros for the IMA ADPCM encoder RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef IMA_ADPCM_ENCODER_DEFINES_SVH
`define IMA_ADPCM_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define IMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ima_adpcm_encoder: same-cycle check failed");
`define IMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ima_adpcm_encoder: next-cycle check failed");
`else
`define IMA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define IMA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/imaenc_pkg.sv
// Types, constants and the step size table of the IMA ADPCM encoder.
// No dependencies.
package imaenc_pkg;

    localparam int SampleW = 16;
    localparam int CodeW   = 4;
    localparam int IdxW    = 7;
    localparam int StepW   = 15;
    localparam int MaxIdx  = 88;

    typedef logic signed [SampleW-1:0] t_sample;
    typedef logic        [IdxW-1:0]    t_idx;
    typedef logic        [StepW-1:0]   t_step;
    typedef logic        [CodeW-1:0]   t_code;

    localparam t_sample PredMax = 16'sh7fff;
    localparam t_sample PredMin = 16'sh8000;
    localparam t_idx    IdxTop  = t_idx'(MaxIdx);

    function automatic t_step step_of(input t_idx idx);
        t_step s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

endpackage

FILE: hw/rtl/ima_adpcm_encoder.sv
// IMA ADPCM encoder top level: input register, combinational quantizer, output register.
// Depends on imaenc_pkg and ima_adpcm_encoder_defines.svh.
//
// Slave channel: one signed 16-bit PCM sample per word on i_s_axis_tdata,
// i_s_axis_tlast marks the final sample of a block.
// Master channel: one byte of two 4-bit codes, earlier code in bits 7..4;
// o_m_axis_tlast marks the final byte of a block. An odd block ends with a
// byte whose low nibble is zero. A byte leaves on every second sample of a block.
// A sample taken into the input register updates the codec state when it
// advances; a byte it completes is valid on the master side from then on.
// Throughput: one sample per cycle while the receiver does not stall, set by
// the registered loop through predictor, step index and step size register.
// The receiver may stall: the output register holds its byte, the input
// register holds one sample, and o_s_axis_tready falls only while both
// are full and the byte is not taken.
// Reset (synchronous, active low) clears predictor, step index, pairing
// and both valid flags; the step size register loads the index-0 step.
`include "ima_adpcm_encoder_defines.svh"

module ima_adpcm_encoder
    import imaenc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] sample
    input  logic        i_s_axis_tlast,   // last_of_block
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] code_byte
    output logic        o_m_axis_tlast    // final_byte
);

    logic    r_in_valid;
    t_sample r_in_sample;
    logic    r_in_last;

    t_sample r_pred;
    t_idx    r_step_index;
    t_step   r_step;
    t_code   r_held;
    logic    r_second;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_final;

    logic    advance;
    t_sample n_pred;
    t_idx    n_step_index;
    t_code   n_code;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;

    always_comb begin
        logic signed [SampleW:0]   diff;
        logic        [SampleW:0]   d0;
        logic        [SampleW:0]   d1;
        logic        [SampleW:0]   d2;
        logic        [SampleW:0]   s0;
        logic        [SampleW:0]   s1;
        logic        [SampleW:0]   s2;
        logic        [SampleW:0]   vp;
        logic signed [SampleW+1:0] nxt;
        logic        [2:0]         mag;
        logic                      sgn;
        logic        [IdxW:0]      ni;

        diff = {r_in_sample[SampleW-1], r_in_sample} - {r_pred[SampleW-1], r_pred};
        sgn  = diff[SampleW];
        d0   = sgn ? (SampleW+1)'(-diff) : (SampleW+1)'(diff);
        s0   = (SampleW+1)'(r_step);
        s1   = s0 >> 1;
        s2   = s0 >> 2;
        vp   = s0 >> 3;
        mag  = 3'd0;
        if (d0 >= s0) begin
            mag[2] = 1'b1;
            d1     = d0 - s0;
            vp     = vp + s0;
        end else begin
            d1 = d0;
        end
        if (d1 >= s1) begin
            mag[1] = 1'b1;
            d2     = d1 - s1;
            vp     = vp + s1;
        end else begin
            d2 = d1;
        end
        if (d2 >= s2) begin
            mag[0] = 1'b1;
            vp     = vp + s2;
        end
        if (sgn) begin
            nxt = {{2{r_pred[SampleW-1]}}, r_pred} - $signed({1'b0, vp});
        end else begin
            nxt = {{2{r_pred[SampleW-1]}}, r_pred} + $signed({1'b0, vp});
        end
        if (nxt > (SampleW+2)'(PredMax)) begin
            n_pred = PredMax;
        end else if (nxt < (SampleW+2)'(PredMin)) begin
            n_pred = PredMin;
        end else begin
            n_pred = nxt[SampleW-1:0];
        end
        if (mag[2]) begin
            ni = {1'b0, r_step_index} + {{(IdxW-2){1'b0}}, mag[1:0], 1'b0}
                 + (IdxW+1)'(2);
            n_step_index = (ni > (IdxW+1)'(MaxIdx)) ? IdxTop : ni[IdxW-1:0];
        end else begin
            ni = {1'b0, r_step_index};
            n_step_index = (r_step_index == '0) ? '0 : r_step_index - t_idx'(1);
        end
        n_code = {sgn, mag};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pred       <= '0;
            r_step_index <= '0;
            r_step       <= step_of('0);
            r_held       <= '0;
            r_second     <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_pred       <= n_pred;
                r_step_index <= n_step_index;
                r_step       <= step_of(n_step_index);
                if (r_second) begin
                    r_out_valid <= 1'b1;
                    r_out_byte  <= {r_held, n_code};
                    r_out_final <= r_in_last;
                    r_second    <= 1'b0;
                end else if (r_in_last) begin
                    r_out_valid <= 1'b1;
                    r_out_byte  <= {n_code, 4'h0};
                    r_out_final <= 1'b1;
                end else begin
                    r_held   <= n_code;
                    r_second <= 1'b1;
                end
            end
        end
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_sample <= i_s_axis_tdata;
            r_in_last   <= i_s_axis_tlast;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_byte;
    assign o_m_axis_tlast  = r_out_final;

    `IMA_ASSERT_SAME(a_idx_range, i_clk, i_rst_n, 1'b1, r_step_index <= IdxTop)
    `IMA_ASSERT_SAME(a_step_match, i_clk, i_rst_n, 1'b1, r_step == step_of(r_step_index))
    `IMA_ASSERT_NEXT(a_pair_done, i_clk, i_rst_n, advance && r_second,
                     !r_second && r_out_valid)
    `IMA_ASSERT_NEXT(a_odd_flush, i_clk, i_rst_n, advance && !r_second && r_in_last,
                     r_out_valid && r_out_final && (r_out_byte[3:0] == 4'h0))

endmodule
